// ===== hw/rtl/updsn_pkg.sv =====
// ----------------------------------------------------------------------------
// updsn_pkg
// Shared constants and types of the URL path dot-segment normalizer.
// ----------------------------------------------------------------------------
package updsn_pkg;

    localparam int DEF_BUFFER_DEPTH = 1024;
    localparam int DEF_MAX_SEGMENTS = 256;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 11;
    localparam int RIDX_W     = 10;
    localparam int LEN_MAX    = (1 << LEN_W) - 1;

    // up to four buffer bytes land in one word: separator, two dots, byte
    localparam int NUM_BANKS  = 4;
    localparam int BANK_SEL_W = 2;

    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    localparam logic [LEN_W-1:0] CAP_RESET = 11'd1024;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

endpackage

// ===== hw/rtl/updsn_ram.sv =====
// ----------------------------------------------------------------------------
// updsn_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module updsn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/url_path_dot_segment_normalizer.sv =====
// ----------------------------------------------------------------------------
// url_path_dot_segment_normalizer
// Streaming normalizer of absolute URL paths: collapses slash runs, drops "."
// segments, pops the last kept segment on "..", and serves buffer reads.
//
//   channel | ports                 | direction | word
//   --------+-----------------------+-----------+------------------------------
//   s_      | valid/ready + 4 fields| in        | push path byte or read request
//   m_      | valid/ready + 5 fields| out       | one result per input word
//   cfg_    | wr_en + wr_data       | in        | output capacity, no wait
//
// One word per cycle while the output is not held; a result passes a pipeline
// register, then an output register, after its word is accepted.
// Buffer bytes live in four byte-wide RAM banks so a segment commit writes its
// separator, held dots and byte together; reads use the same banks.
// Segment starts live in a stack RAM; its top is cached in a register and
// refilled from a registered stack read after a pop.
// Reset is synchronous and clears control state only; no RAM clearing pass.
// m_ready low holds the output; s_ready drops once both stages are full and m_ready is low.
// ----------------------------------------------------------------------------
module url_path_dot_segment_normalizer
    import updsn_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_wr_en,
    input  logic [LEN_W-1:0]  cfg_wr_data,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [BYTE_W-1:0] s_path_byte,
    input  logic              s_is_last,
    input  logic [RIDX_W-1:0] s_read_index,

    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_path_done,
    output logic [1:0]        m_status,
    output logic [LEN_W-1:0]  m_normalized_length,
    output logic              m_ends_slash,
    output logic [BYTE_W-1:0] m_read_data
);

    localparam int BANK_DEPTH = (BUFFER_DEPTH + NUM_BANKS - 1) / NUM_BANKS;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int DEPTH_W    = $clog2(MAX_SEGMENTS + 1);
    localparam int SIDX_W     = $clog2(MAX_SEGMENTS);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_SEGMENTS);
    localparam logic [LEN_W-1:0]   CAP_CLAMP =
        LEN_W'((BUFFER_DEPTH < LEN_MAX) ? BUFFER_DEPTH : LEN_MAX);

    typedef struct packed {
        logic                  path_done;
        logic [1:0]            status;
        logic [LEN_W-1:0]      length;
        logic                  ends_slash;
        logic                  is_read;
        logic [BANK_SEL_W-1:0] bank;
        logic                  rd_ok;
    } result_t;

    // configuration
    logic [LEN_W-1:0] cap_reg;
    logic [LEN_W-1:0] eff_cap;

    // path state
    logic [LEN_W-1:0]   wp_reg, wp_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               kept_reg, kept_next;
    logic [1:0]         dots_reg, dots_next;
    logic               started_reg, started_next;
    status_t            err_reg, err_next;
    logic [LEN_W-1:0]   top_reg, top_next;
    logic               refill_pend_reg, refill_pend_next;

    // handshake and pipeline
    logic    accept, push_acc, rd_acc;
    logic    p1_valid_reg, p1_valid_next;
    result_t p1_reg, res_next;
    logic    p1_adv;
    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg;
    logic [BYTE_W-1:0] m_read_data_reg, m_read_data_next;

    // step helpers
    logic             is_slash, is_dot, slash_need, pop_req;
    logic [LEN_W:0]   wp_p1, seg_start, seg_end, cap_ext;

    // buffer write description
    logic [LEN_W-1:0]  wr_base;
    logic [2:0]        wr_cnt;
    logic              n_slash;
    logic [1:0]        n_dot;
    logic [BYTE_W-1:0] wr_fill;

    // stack port
    logic               pop_en, stk_push, stk_rd_en;
    logic [DEPTH_W-1:0] stk_ridx;
    logic [LEN_W-1:0]   stk_rdata;

    // bank ports
    logic                  bank_we    [NUM_BANKS];
    logic [BANK_AW-1:0]    bank_waddr [NUM_BANKS];
    logic [BYTE_W-1:0]     bank_wdata [NUM_BANKS];
    logic [BANK_AW-1:0]    bank_raddr;
    logic [BYTE_W-1:0]     bank_rdata [NUM_BANKS];
    logic [BANK_SEL_W-1:0] bank_rel   [NUM_BANKS];
    logic [LEN_W-1:0]      bank_pos   [NUM_BANKS];

    // ------------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------------
    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !p1_valid_reg || !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign push_acc = accept && (s_req_type == REQ_PUSH);
    assign rd_acc   = accept && (s_req_type == REQ_READ);

    // ------------------------------------------------------------------------
    // per-word step
    // ------------------------------------------------------------------------
    assign eff_cap    = (cap_reg < CAP_CLAMP) ? cap_reg : CAP_CLAMP;
    assign cap_ext    = {1'b0, eff_cap};
    assign is_slash   = (s_path_byte == CH_SLASH);
    assign is_dot     = (s_path_byte == CH_DOT);
    assign slash_need = (wp_reg > LEN_W'(1));
    assign wp_p1      = {1'b0, wp_reg} + (LEN_W+1)'(1);
    assign seg_start  = {1'b0, wp_reg} + (LEN_W+1)'(slash_need);
    assign seg_end    = seg_start + (LEN_W+1)'(dots_reg) + (LEN_W+1)'(1);
    assign stk_ridx   = depth_reg - DEPTH_W'(2);

    always_comb begin
        wp_next      = wp_reg;
        depth_next   = depth_reg;
        kept_next    = kept_reg;
        dots_next    = dots_reg;
        started_next = started_reg;
        err_next     = err_reg;
        wr_base      = wp_reg;
        wr_cnt       = 3'd0;
        n_slash      = 1'b0;
        n_dot        = 2'd0;
        wr_fill      = s_path_byte;
        pop_req      = 1'b0;
        pop_en       = 1'b0;
        stk_push     = 1'b0;
        stk_rd_en    = 1'b0;
        res_next     = '0;

        if (push_acc) begin
            if (!started_reg) begin
                started_next = 1'b1;
                if (!is_slash || eff_cap == '0) begin
                    err_next = ST_INVALID;
                end else begin
                    wr_base = '0;
                    wr_cnt  = 3'd1;
                    wp_next = LEN_W'(1);
                end
            end else if (err_reg == ST_OK) begin
                if (is_slash) begin
                    pop_req   = !kept_reg && (dots_reg == 2'd2);
                    kept_next = 1'b0;
                    dots_next = 2'd0;
                end else if (!kept_reg) begin
                    if (is_dot && dots_reg != 2'd2) begin
                        dots_next = dots_reg + 2'd1;
                        // a path ending in ".." pops as if a slash followed
                        pop_req   = s_is_last && (dots_reg == 2'd1);
                    end else if (slash_need && wp_p1 > cap_ext) begin
                        err_next = ST_OVERFLOW;
                    end else begin
                        // separator goes in even if the segment then fails
                        n_slash = slash_need;
                        wr_cnt  = {2'b00, slash_need};
                        if (depth_reg >= DEPTH_MAX) begin
                            err_next = ST_INVALID;
                        end else begin
                            stk_push   = 1'b1;
                            depth_next = depth_reg + DEPTH_W'(1);
                            if (seg_end > cap_ext) begin
                                err_next = ST_OVERFLOW;
                            end else begin
                                n_dot     = dots_reg;
                                wr_cnt    = {2'b00, slash_need} + {1'b0, dots_reg} + 3'd1;
                                wp_next   = seg_end[LEN_W-1:0];
                                kept_next = 1'b1;
                                dots_next = 2'd0;
                            end
                        end
                    end
                end else if (wp_p1 > cap_ext) begin
                    err_next = ST_OVERFLOW;
                end else begin
                    wr_cnt  = 3'd1;
                    wp_next = wp_p1[LEN_W-1:0];
                end
            end

            // pop: roll back to the position held before the segment's separator
            if (pop_req && depth_reg != '0) begin
                pop_en     = 1'b1;
                depth_next = depth_reg - DEPTH_W'(1);
                wp_next    = top_reg;
                wr_base    = top_reg;
                wr_cnt     = 3'd1;
                n_slash    = 1'b0;
                n_dot      = 2'd0;
                wr_fill    = CH_NUL;
                stk_rd_en  = (depth_reg >= DEPTH_W'(2));
            end

            if (s_is_last) begin
                res_next.path_done  = 1'b1;
                res_next.status     = err_next;
                res_next.length     = (err_next == ST_OK) ? wp_next : '0;
                res_next.ends_slash = is_slash;
                wp_next      = '0;
                depth_next   = '0;
                kept_next    = 1'b0;
                dots_next    = 2'd0;
                started_next = 1'b0;
                err_next     = ST_OK;
            end
        end else if (rd_acc) begin
            res_next.is_read = 1'b1;
            res_next.bank    = s_read_index[BANK_SEL_W-1:0];
            res_next.rd_ok   = (32'(s_read_index) < 32'(BUFFER_DEPTH));
        end
    end

    // cached stack top: a push wins over a refill landing in the same cycle
    always_comb begin
        top_next         = top_reg;
        refill_pend_next = stk_rd_en;
        if (stk_push) begin
            top_next = wp_reg;
        end else if (refill_pend_reg) begin
            top_next = stk_rdata;
        end
    end

    // ------------------------------------------------------------------------
    // bank mapping of the write run
    // ------------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < NUM_BANKS; k++) begin
            bank_rel[k]   = BANK_SEL_W'(k) - wr_base[BANK_SEL_W-1:0];
            bank_pos[k]   = wr_base + LEN_W'(bank_rel[k]);
            bank_we[k]    = ({1'b0, bank_rel[k]} < wr_cnt);
            bank_waddr[k] = BANK_AW'(bank_pos[k][LEN_W-1:BANK_SEL_W]);
            if ({1'b0, bank_rel[k]} < {2'b00, n_slash}) begin
                bank_wdata[k] = CH_SLASH;
            end else if ({1'b0, bank_rel[k]} < ({2'b00, n_slash} + {1'b0, n_dot})) begin
                bank_wdata[k] = CH_DOT;
            end else begin
                bank_wdata[k] = wr_fill;
            end
        end
    end

    assign bank_raddr = BANK_AW'(s_read_index[RIDX_W-1:BANK_SEL_W]);

    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        updsn_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .aclk  (aclk),
            .we    (bank_we[g]),
            .waddr (bank_waddr[g]),
            .wdata (bank_wdata[g]),
            .re    (rd_acc),
            .raddr (bank_raddr),
            .rdata (bank_rdata[g])
        );
    end

    updsn_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_push),
        .waddr (depth_reg[SIDX_W-1:0]),
        .wdata (wp_reg),
        .re    (stk_rd_en),
        .raddr (stk_ridx[SIDX_W-1:0]),
        .rdata (stk_rdata)
    );

    // ------------------------------------------------------------------------
    // pipeline and output
    // ------------------------------------------------------------------------
    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (p1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        m_read_data_next = '0;
        if (p1_reg.is_read && p1_reg.rd_ok) begin
            m_read_data_next = bank_rdata[p1_reg.bank];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg         <= CAP_RESET;
            wp_reg          <= '0;
            depth_reg       <= '0;
            kept_reg        <= 1'b0;
            dots_reg        <= 2'd0;
            started_reg     <= 1'b0;
            err_reg         <= ST_OK;
            refill_pend_reg <= 1'b0;
            p1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            wp_reg          <= wp_next;
            depth_reg       <= depth_next;
            kept_reg        <= kept_next;
            dots_reg        <= dots_next;
            started_reg     <= started_next;
            err_reg         <= err_next;
            refill_pend_reg <= refill_pend_next;
            p1_valid_reg    <= p1_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (accept) begin
            p1_reg <= res_next;
        end
        if (p1_adv) begin
            m_res_reg       <= p1_reg;
            m_read_data_reg <= m_read_data_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_path_done         = m_res_reg.path_done;
    assign m_status            = m_res_reg.status;
    assign m_normalized_length = m_res_reg.length;
    assign m_ends_slash        = m_res_reg.ends_slash;
    assign m_read_data         = m_read_data_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_refill_before_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        refill_pend_reg |-> !pop_en)
        else $error("pop while stack top refill still in flight");

    a_push_pop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_push |-> !pop_en)
        else $error("stack push and pop in the same word");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_MAX)
        else $error("segment depth beyond limit");

    a_err_needs_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ST_OK) |-> started_reg)
        else $error("error held outside a path");

    a_idle_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_path_done) |-> (m_status == ST_OK && m_normalized_length == '0))
        else $error("status or length set on a word that ends no path");

endmodule
